// ----- rtl/ecd_pkg.sv -----
// shared types, constants and the month table for the epoch to calendar date converter
`default_nettype none

package ecd_pkg;

  // number of register stages from input to result
  localparam int unsigned NST = 19;

  typedef logic [57:0] epoch_us_t;
  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [9:0]  milli_t;
  typedef logic [9:0]  micro_t;

  typedef struct packed {
    hour_t   hour;
    minute_t minute;
    second_t second;
    milli_t  millisecond;
    micro_t  microsecond;
  } tod_t;

  // first count past 9999-12-31 23:59:59.999999
  localparam epoch_us_t US_LIMIT = 58'd253402300800000000;

  localparam logic [13:0] D_US          = 14'd15625;   // 1e6 / 64
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [21:0] EPOCH_DAYS    = 22'd719468;  // days from 0000-03-01 to 1970-01-01
  localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
  localparam logic [17:0] DOE_LAST      = 18'd146096;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
  localparam logic [9:0]  US_PER_MS     = 10'd1000;

  // exact reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s over the range in use
  localparam int unsigned SH_US   = 45;
  localparam logic [31:0] M_US    = 32'(((64'd1 << SH_US) + 64'd15624) / 64'd15625);
  localparam int unsigned SH_DAY  = 41;
  localparam logic [31:0] M_DAY   = 32'(((64'd1 << SH_DAY) + 64'd674) / 64'd675);
  localparam int unsigned SH_ERA  = 40;
  localparam logic [22:0] M_ERA   = 23'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
  localparam int unsigned SH_Q4   = 29;
  localparam logic [18:0] M_Q4    = 19'(((64'd1 << SH_Q4) + 64'd1459) / 64'd1460);
  localparam int unsigned SH_C    = 34;
  localparam logic [18:0] M_C     = 19'(((64'd1 << SH_C) + 64'd36523) / 64'd36524);
  localparam int unsigned SH_Y    = 27;
  localparam logic [18:0] M_Y     = 19'(((64'd1 << SH_Y) + 64'd364) / 64'd365);
  localparam int unsigned SH_C100 = 16;
  localparam logic [9:0]  M_C100  = 10'(((64'd1 << SH_C100) + 64'd99) / 64'd100);
  localparam int unsigned SH_MP   = 19;
  localparam logic [11:0] M_MP    = 12'(((64'd1 << SH_MP) + 64'd152) / 64'd153);
  localparam int unsigned SH_H    = 29;
  localparam logic [17:0] M_H     = 18'(((64'd1 << SH_H) + 64'd3599) / 64'd3600);
  localparam int unsigned SH_M    = 23;
  localparam logic [17:0] M_M     = 18'(((64'd1 << SH_M) + 64'd59) / 64'd60);
  localparam int unsigned SH_MS   = 30;
  localparam logic [20:0] M_MS    = 21'(((64'd1 << SH_MS) + 64'd999) / 64'd1000);

  // first day of each month within a year that starts in march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ecd_if.sv -----
// valid/ready channel interfaces for the timestamp input and the date result
`default_nettype none

interface ecd_in_if import ecd_pkg::*; ();
  logic      valid;
  logic      ready;
  epoch_us_t epoch_microseconds;

  modport source (output valid, output epoch_microseconds, input ready);
  modport sink   (input valid, input epoch_microseconds, output ready);
endinterface

interface ecd_out_if import ecd_pkg::*; ();
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  hour_t   hour;
  minute_t minute;
  second_t second;
  milli_t  millisecond;
  micro_t  microsecond;
  logic    out_of_range;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output millisecond, output microsecond,
                  output out_of_range, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input millisecond, input microsecond,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/epoch_to_calendar_date_core.sv -----
// Unix microsecond timestamp to Gregorian date and time of day converter.
//
// in_ch carries one 58-bit count of microseconds since 1970-01-01 00:00:00 UTC per item;
// out_ch returns one item per input: year, month, day, hour, minute, second,
// millisecond, microsecond and an out_of_range flag. Counts past
// 9999-12-31 23:59:59.999999 set out_of_range and give zero in every other field.
// Both channels use valid/ready; an item moves on a clock edge with both high.
//
// The datapath is a 19-stage pipeline built from constant divisions done as
// multiplications by exact reciprocals (at most one 31x32 product per stage), plus
// three digit steps of 18, 17 and 17 bits that split the count into seconds. Throughput
// is one item per cycle while out_ch.ready is high; a result shows on out_ch once it has passed every stage.
// Each stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up when the receiver stalls and in_ch.ready stays
// high until all 19 stages hold items. Nothing is lost or repeated under stalls.
// Reset (rst_n low at a clock edge) empties every stage.
`default_nettype none

module epoch_to_calendar_date_core import ecd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  ecd_in_if.sink    in_ch,
  ecd_out_if.source out_ch
);

  logic [NST-1:0] en;
  logic [NST-1:0] v_r;
  logic [NST-1:0] oor_r;

  // stage registers
  epoch_us_t   n_r;
  logic [17:0] x1_r;
  logic [49:0] p1_r;
  logic [39:0] n1_r;
  logic [4:0]  q1_2_r;
  logic [13:0] r1_r;
  logic [39:0] n2_r;
  logic [30:0] x2_r;
  logic [62:0] p3_r;
  logic [4:0]  q1_3_r;
  logic [22:0] nlo3_r;
  logic [4:0]  q1_4_r;
  logic [16:0] q2_4_r;
  logic [13:0] r2_r;
  logic [22:0] nlo4_r;
  logic [30:0] x3_r;
  logic [62:0] p5_r;
  logic [4:0]  q1_5_r;
  logic [16:0] q2_5_r;
  logic [5:0]  lo6_r;
  logic [38:0] sec_r;
  logic [19:0] usec6_r;
  logic [62:0] p7_r;
  logic [16:0] sec7_r;
  logic [19:0] usec7_r;
  logic [21:0] days_r;
  logic [16:0] sod8_r;
  logic [19:0] usec8_r;
  logic [21:0] z9_r;
  logic [34:0] ph_r;
  logic [34:0] pm_r;
  logic [40:0] pms_r;
  logic [16:0] sod9_r;
  logic [19:0] usec9_r;
  logic [44:0] pe_r;
  logic [21:0] z10_r;
  hour_t       hour10_r;
  logic [10:0] mtot10_r;
  second_t     sec10_r;
  milli_t      ms10_r;
  micro_t      us10_r;
  logic [4:0]  era_r [11:15];
  logic [17:0] doe_r [11:15];
  tod_t        tod_r [11:17];
  logic [36:0] pa_r;
  logic [36:0] pb_r;
  logic [17:0] t_r;
  logic [36:0] py_r;
  logic [8:0]  yoe_r;
  logic [8:0]  doy16_r;
  year_t       ybase16_r;
  logic [23:0] pmp_r;
  logic [8:0]  doy17_r;
  year_t       ybase17_r;
  year_t       year_r;
  month_t      month_r;
  day_t        day_r;
  tod_t        tod_out_r;

  // next values
  logic [4:0]  q1_nxt;
  logic [13:0] r1_nxt;
  logic [16:0] q2_nxt;
  logic [13:0] r2_nxt;
  logic [16:0] q3_nxt;
  logic [13:0] r3_nxt;
  logic [21:0] days_nxt;
  logic [16:0] sod_nxt;
  logic [10:0] mtot_nxt;
  milli_t      ms_nxt;
  logic [4:0]  era_nxt;
  logic [17:0] doe_nxt;
  tod_t        tod_nxt;
  logic [17:0] t_nxt;
  logic [2:0]  cent_nxt;
  logic [18:0] yc_nxt;
  logic [8:0]  doy_nxt;
  logic [11:0] mpx_nxt;
  logic [3:0]  mp_nxt;
  month_t      month_nxt;
  year_t       year_nxt;
  day_t        day_nxt;

  // a stage loads when it is empty or its successor moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // seconds and microseconds: count >> 6 divided by 15625 in three digit steps
  always_comb begin
    q1_nxt   = p1_r[SH_US+4:SH_US];
    r1_nxt   = 14'(x1_r - 18'(18'(q1_nxt) * 18'(D_US)));
    q2_nxt   = p3_r[SH_US+16:SH_US];
    r2_nxt   = 14'(x2_r - 31'(31'(q2_nxt) * 31'(D_US)));
    q3_nxt   = p5_r[SH_US+16:SH_US];
    r3_nxt   = 14'(x3_r - 31'(31'(q3_nxt) * 31'(D_US)));
    // day count: seconds >> 7 divided by 675
    days_nxt = p7_r[SH_DAY+21:SH_DAY];
    sod_nxt  = 17'(sec7_r - 17'(17'(days_nxt) * SEC_PER_DAY));
    mtot_nxt = pm_r[SH_M+10:SH_M];
    ms_nxt   = pms_r[SH_MS+9:SH_MS];
    // era and day of era
    era_nxt  = pe_r[SH_ERA+4:SH_ERA];
    doe_nxt  = 18'(z10_r - 22'(22'(era_nxt) * 22'(DAYS_PER_ERA)));
    tod_nxt.hour        = hour10_r;
    tod_nxt.minute      = 6'(mtot10_r - 11'(11'(hour10_r) * 11'(MIN_PER_HOUR)));
    tod_nxt.second      = sec10_r;
    tod_nxt.millisecond = ms10_r;
    tod_nxt.microsecond = us10_r;
    // year of era, with the leap day corrections
    t_nxt    = 18'(doe_r[12] - 18'(pa_r[SH_Q4+6:SH_Q4]) + 18'(pb_r[SH_C+2:SH_C])
                   - 18'(doe_r[12] == DOE_LAST));
    yc_nxt   = 19'(yoe_r) * 19'(M_C100);
    cent_nxt = yc_nxt[SH_C100+2:SH_C100];
    doy_nxt  = 9'(doe_r[15] - 18'(18'(yoe_r) * 18'(DAYS_PER_YEAR) + 18'(yoe_r >> 2)
                                  - 18'(cent_nxt)));
    mpx_nxt  = 12'(12'(doy16_r) * 12'd5 + 12'd2);
    // month from the march-based month index
    mp_nxt    = pmp_r[SH_MP+3:SH_MP];
    month_nxt = (mp_nxt < 4'd10) ? 4'(mp_nxt + 4'd3) : 4'(mp_nxt - 4'd9);
    year_nxt  = 14'(ybase17_r + 14'(month_nxt <= 4'd2));
    day_nxt   = 5'(doy17_r - month_start(mp_nxt) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_r      <= in_ch.epoch_microseconds;
      oor_r[0] <= (in_ch.epoch_microseconds >= US_LIMIT);
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        oor_r[k] <= oor_r[k-1];
      end
    end
    if (en[1]) begin
      x1_r <= n_r[57:40];
      p1_r <= 50'(n_r[57:40]) * 50'(M_US);
      n1_r <= n_r[39:0];
    end
    if (en[2]) begin
      q1_2_r <= q1_nxt;
      r1_r   <= r1_nxt;
      n2_r   <= n1_r;
    end
    if (en[3]) begin
      x2_r   <= {r1_r, n2_r[39:23]};
      p3_r   <= 63'({r1_r, n2_r[39:23]}) * 63'(M_US);
      q1_3_r <= q1_2_r;
      nlo3_r <= n2_r[22:0];
    end
    if (en[4]) begin
      q1_4_r <= q1_3_r;
      q2_4_r <= q2_nxt;
      r2_r   <= r2_nxt;
      nlo4_r <= nlo3_r;
    end
    if (en[5]) begin
      x3_r   <= {r2_r, nlo4_r[22:6]};
      p5_r   <= 63'({r2_r, nlo4_r[22:6]}) * 63'(M_US);
      q1_5_r <= q1_4_r;
      q2_5_r <= q2_4_r;
      lo6_r  <= nlo4_r[5:0];
    end
    if (en[6]) begin
      sec_r   <= {q1_5_r, q2_5_r, q3_nxt};
      usec6_r <= {r3_nxt, lo6_r};
    end
    if (en[7]) begin
      p7_r    <= 63'(sec_r[37:7]) * 63'(M_DAY);
      sec7_r  <= sec_r[16:0];
      usec7_r <= usec6_r;
    end
    if (en[8]) begin
      days_r  <= days_nxt;
      sod8_r  <= sod_nxt;
      usec8_r <= usec7_r;
    end
    if (en[9]) begin
      z9_r    <= 22'(days_r + EPOCH_DAYS);
      ph_r    <= 35'(sod8_r) * 35'(M_H);
      pm_r    <= 35'(sod8_r) * 35'(M_M);
      pms_r   <= 41'(usec8_r) * 41'(M_MS);
      sod9_r  <= sod8_r;
      usec9_r <= usec8_r;
    end
    if (en[10]) begin
      pe_r     <= 45'(z9_r) * 45'(M_ERA);
      z10_r    <= z9_r;
      hour10_r <= ph_r[SH_H+4:SH_H];
      mtot10_r <= mtot_nxt;
      sec10_r  <= 6'(sod9_r - 17'(17'(mtot_nxt) * 17'(SEC_PER_MIN)));
      ms10_r   <= ms_nxt;
      us10_r   <= 10'(usec9_r - 20'(20'(ms_nxt) * 20'(US_PER_MS)));
    end
    if (en[11]) begin
      era_r[11] <= era_nxt;
      doe_r[11] <= doe_nxt;
      tod_r[11] <= tod_nxt;
    end
    for (int k = 12; k <= 15; k++) begin
      if (en[k]) begin
        era_r[k] <= era_r[k-1];
        doe_r[k] <= doe_r[k-1];
      end
    end
    for (int k = 12; k <= 17; k++) begin
      if (en[k]) begin
        tod_r[k] <= tod_r[k-1];
      end
    end
    if (en[12]) begin
      pa_r <= 37'(doe_r[11]) * 37'(M_Q4);
      pb_r <= 37'(doe_r[11]) * 37'(M_C);
    end
    if (en[13]) begin
      t_r <= t_nxt;
    end
    if (en[14]) begin
      py_r <= 37'(t_r) * 37'(M_Y);
    end
    if (en[15]) begin
      yoe_r <= py_r[SH_Y+8:SH_Y];
    end
    if (en[16]) begin
      doy16_r   <= doy_nxt;
      ybase16_r <= 14'(14'(yoe_r) + 14'(era_r[15]) * 14'(YEARS_PER_ERA));
    end
    if (en[17]) begin
      pmp_r     <= 24'(mpx_nxt) * 24'(M_MP);
      doy17_r   <= doy16_r;
      ybase17_r <= ybase16_r;
    end
    if (en[18]) begin
      // out of range items give zero everywhere but the flag
      year_r    <= oor_r[17] ? '0 : year_nxt;
      month_r   <= oor_r[17] ? '0 : month_nxt;
      day_r     <= oor_r[17] ? '0 : day_nxt;
      tod_out_r <= oor_r[17] ? '0 : tod_r[17];
    end
  end

  assign out_ch.valid        = v_r[NST-1];
  assign out_ch.year         = year_r;
  assign out_ch.month        = month_r;
  assign out_ch.day          = day_r;
  assign out_ch.hour         = tod_out_r.hour;
  assign out_ch.minute       = tod_out_r.minute;
  assign out_ch.second       = tod_out_r.second;
  assign out_ch.millisecond  = tod_out_r.millisecond;
  assign out_ch.microsecond  = tod_out_r.microsecond;
  assign out_ch.out_of_range = oor_r[NST-1];

endmodule

`default_nettype wire

// ----- rtl/ecd_checker.sv -----
// port-level checks on the converter result channel, bound to the top level
`default_nettype none

module ecd_checker import ecd_pkg::*; (
  input wire          clk,
  input wire          rst_n,
  input wire          out_valid,
  input wire          out_ready,
  input wire year_t   year,
  input wire month_t  month,
  input wire day_t    day,
  input wire hour_t   hour,
  input wire minute_t minute,
  input wire second_t second,
  input wire milli_t  millisecond,
  input wire micro_t  microsecond,
  input wire          out_of_range
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({year, month, day, hour, minute,
                                 second, millisecond, microsecond, out_of_range}))
    else $error("result changed while stalled");

  // past year 9999 every field but the flag is zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> year == '0 && month == '0 && day == '0 && hour == '0
      && minute == '0 && second == '0 && millisecond == '0 && microsecond == '0)
    else $error("out of range item with non-zero fields");

  // in-range dates stay within the calendar
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_of_range |-> year >= 14'd1970 && year <= 14'd9999
      && month >= 4'd1 && month <= 4'd12 && day >= 5'd1)
    else $error("date field out of range");

  // time of day fields stay within their units
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60
      && millisecond < 10'd1000 && microsecond < 10'd1000)
    else $error("time of day field out of range");

endmodule

bind epoch_to_calendar_date_core ecd_checker u_ecd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .year         (out_ch.year),
  .month        (out_ch.month),
  .day          (out_ch.day),
  .hour         (out_ch.hour),
  .minute       (out_ch.minute),
  .second       (out_ch.second),
  .millisecond  (out_ch.millisecond),
  .microsecond  (out_ch.microsecond),
  .out_of_range (out_ch.out_of_range)
);

`default_nettype wire
